// File: rtl/bkht_pkg.sv
// shared types, codes and defaults of the bucketed key handle table
package bkht_pkg;

  // default geometry
  localparam int BUCKETS_DEF = 16;
  localparam int WAYS_DEF    = 16;

  // field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] lookup_key;
    logic [HANDLE_W-1:0]     item_handle;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_handle;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clear;
    logic exec;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
  } dp_stat_t;

endpackage

// File: rtl/bkht_ctrl.sv
// controller state machine: clearing pass, idle, compare and write back
module bkht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output bkht_pkg::ctl_cmd_t  cmd,
  input  bkht_pkg::dp_stat_t  stat
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.clear  = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/bkht_datapath.sv
// datapath: bucket row memory, parallel way compare, row write back, result register
module bkht_datapath #(
  parameter int BUCKETS = bkht_pkg::BUCKETS_DEF,
  parameter int WAYS    = bkht_pkg::WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bkht_pkg::ctl_cmd_t  cmd,
  output bkht_pkg::dp_stat_t  stat,
  input  bkht_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bkht_pkg::out_item_t out_item
);

  localparam int BW = $clog2(BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  // bucket row memories
  logic [WAYS-1:0]                                  valid_mem_r  [BUCKETS];
  logic [WAYS-1:0][bkht_pkg::KEY_W-1:0]             key_mem_r    [BUCKETS];
  logic [WAYS-1:0][bkht_pkg::HANDLE_W-1:0]          handle_mem_r [BUCKETS];

  // registered row read
  logic [WAYS-1:0]                                  rd_valid_r;
  logic [WAYS-1:0][bkht_pkg::KEY_W-1:0]             rd_keys_r;
  logic [WAYS-1:0][bkht_pkg::HANDLE_W-1:0]          rd_handles_r;

  bkht_pkg::in_item_t  item_r;
  logic [BW-1:0]       bucket_r;
  logic [BW-1:0]       clr_cnt_r;
  logic [BW-1:0]       clr_cnt_nxt;

  logic [WAYS-1:0]     hit_vec;
  logic [WAYS-1:0]     free_vec;
  logic                hit_any;
  logic                free_any;
  logic [WW-1:0]       hit_idx;
  logic [WW-1:0]       free_idx;
  logic [WW-1:0]       tgt_idx;

  logic [WAYS-1:0]                                  valid_nxt;
  logic [WAYS-1:0][bkht_pkg::KEY_W-1:0]             keys_nxt;
  logic [WAYS-1:0][bkht_pkg::HANDLE_W-1:0]          handles_nxt;
  logic                                             wr_en;
  bkht_pkg::out_item_t                              res;

  logic                out_valid_r;
  bkht_pkg::out_item_t out_item_r;

  // clearing pass counter
  assign clr_cnt_nxt     = clr_cnt_r + 1'b1;
  assign stat.clear_done = (clr_cnt_r == BW'(BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // latch item and read its bucket row
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r       <= in_item;
      bucket_r     <= in_item.lookup_key[BW-1:0];
      rd_valid_r   <= valid_mem_r[in_item.lookup_key[BW-1:0]];
      rd_keys_r    <= key_mem_r[in_item.lookup_key[BW-1:0]];
      rd_handles_r <= handle_mem_r[in_item.lookup_key[BW-1:0]];
    end
  end

  // per-way match and free flags
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = rd_valid_r[w] && (rd_keys_r[w] == $unsigned(item_r.lookup_key));
      free_vec[w] = !rd_valid_r[w];
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;

  // lowest-numbered matching and free ways
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = WW'(w);
      end
      if (free_vec[w]) begin
        free_idx = WW'(w);
      end
    end
  end

  assign tgt_idx = hit_any ? hit_idx : free_idx;

  // new row contents and result
  always_comb begin
    valid_nxt        = rd_valid_r;
    keys_nxt         = rd_keys_r;
    handles_nxt      = rd_handles_r;
    wr_en            = 1'b0;
    res.status       = bkht_pkg::ST_MISS;
    res.found_handle = '0;
    unique case (item_r.cmd)
      bkht_pkg::CMD_INSERT: begin
        if (hit_any || free_any) begin
          valid_nxt[tgt_idx]   = 1'b1;
          keys_nxt[tgt_idx]    = $unsigned(item_r.lookup_key);
          handles_nxt[tgt_idx] = item_r.item_handle;
          wr_en                = cmd.exec;
          res.status           = bkht_pkg::ST_OK;
          res.found_handle     = item_r.item_handle;
        end else begin
          res.status = bkht_pkg::ST_FULL;
        end
      end
      bkht_pkg::CMD_REMOVE: begin
        if (hit_any) begin
          valid_nxt[hit_idx] = 1'b0;
          wr_en              = cmd.exec;
          res.status         = bkht_pkg::ST_OK;
          res.found_handle   = rd_handles_r[hit_idx];
        end
      end
      default: begin
        // lookup, and the unused code behaves the same
        if (hit_any) begin
          res.status       = bkht_pkg::ST_OK;
          res.found_handle = rd_handles_r[hit_idx];
        end
      end
    endcase
  end

  // row write back and clearing pass
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      valid_mem_r[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      valid_mem_r[bucket_r]  <= valid_nxt;
      key_mem_r[bucket_r]    <= keys_nxt;
      handle_mem_r[bucket_r] <= handles_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/bucketed_key_handle_table.sv
// top level of the bucketed key handle table
// timing: the accepting edge registers the item and its bucket row; in the
//   exec state the row is compared, written back and the result registered
// pacing: one item in flight; busy stays high until that exec state is over
// reset: a clearing pass frees every slot, busy stays high
//   meanwhile; results cannot be stalled, out_valid lasts exactly one cycle
module bucketed_key_handle_table #(
  parameter int BUCKETS = bkht_pkg::BUCKETS_DEF,
  parameter int WAYS    = bkht_pkg::WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bkht_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bkht_pkg::out_item_t out_item
);

  bkht_pkg::ctl_cmd_t cmd;
  bkht_pkg::dp_stat_t stat;

  // controller
  bkht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // datapath
  bkht_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // an accepted item yields its result strobe once its exec state is over
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted item gave no result");

  // only one item in flight, so strobes never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result is shown only once the block is ready again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

endmodule
